/* rtl/hashed_name_registry_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the hashed name registry
// ----------------------------------------------------------------------------
`ifndef HASHED_NAME_REGISTRY_MACROS_SVH
`define HASHED_NAME_REGISTRY_MACROS_SVH

// clocked property, off during reset
`define HNR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property, also checked during reset
`define HNR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/hnr_pkg.sv */
// ----------------------------------------------------------------------------
// hnr_pkg
// Shared types and constants of the hashed name registry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package hnr_pkg;

  localparam int ENTRIES      = 256;
  localparam int IDX_W        = $clog2(ENTRIES);
  localparam int CNT_W        = $clog2(ENTRIES + 1);
  localparam int TEXT_BYTES   = 4096;
  localparam int TADDR_W      = $clog2(TEXT_BYTES);
  localparam int TFILL_W      = $clog2(TEXT_BYTES + 1);
  localparam int NAME_MAX_LEN = 255;
  localparam int NAME_W       = $clog2(NAME_MAX_LEN);
  localparam int NCNT_W       = $clog2(NAME_MAX_LEN + 2);
  localparam int Q_DEPTH      = 2;
  localparam int Q_PTR_W      = $clog2(Q_DEPTH);
  localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_SEALED   = 3'd2;
  localparam logic [2:0] ST_CONFLICT = 3'd3;
  localparam logic [2:0] ST_CAPACITY = 3'd4;
  localparam logic [2:0] ST_NOTFOUND = 3'd5;

  localparam logic [2:0] CFG_FIRST   = 3'd0;
  localparam logic [2:0] CFG_LAST    = 3'd1;
  localparam logic [2:0] CFG_ELIMIT  = 3'd2;
  localparam logic [2:0] CFG_TLIMIT  = 3'd3;
  localparam logic [2:0] CFG_SEALED  = 3'd4;

  localparam logic MODE_REG    = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [7:0]  name_byte;
    logic        last;
    logic [31:0] lookup_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] result_id;
    logic        is_builtin;
    logic [7:0]  builtin_slot;
    logic [11:0] text_start;
    logic [7:0]  text_len;
  } out_item_t;

  typedef struct packed {
    logic [31:0] builtin_first_id;
    logic [31:0] builtin_last_id;
    logic [8:0]  entry_limit;
    logic [12:0] text_limit;
    logic        sealed;
  } cfg_t;

  typedef struct packed {
    logic              is_lookup;
    logic              bad;
    logic [31:0]       id;
    logic [NCNT_W-1:0] len;
  } cmd_t;

  typedef struct packed {
    logic [31:0]        id;
    logic [TADDR_W-1:0] off;
    logic [7:0]         len;
  } entry_t;

  typedef struct packed {
    logic              done;
    logic [NAME_W-1:0] addr;
  } nbuf_ctl_t;

endpackage
`default_nettype wire

/* rtl/hnr_queue.sv */
// ----------------------------------------------------------------------------
// hnr_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module hnr_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_valid,
  output      logic          wr_ready,
  input  wire hnr_pkg::cmd_t wr_cmd,
  output      logic          rd_valid,
  input  wire logic          rd_pop,
  output      hnr_pkg::cmd_t rd_cmd
);
  hnr_pkg::cmd_t slots [hnr_pkg::Q_DEPTH];
  logic [hnr_pkg::Q_PTR_W-1:0] wp;
  logic [hnr_pkg::Q_PTR_W-1:0] rp;
  logic [hnr_pkg::Q_CNT_W-1:0] cnt;
  logic push;
  logic pop;

  assign wr_ready = (cnt != hnr_pkg::Q_CNT_W'(hnr_pkg::Q_DEPTH));
  assign rd_valid = (cnt != '0);
  assign rd_cmd   = slots[rp];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      cnt <= cnt + hnr_pkg::Q_CNT_W'(push) - hnr_pkg::Q_CNT_W'(pop);
    end
  end
endmodule
`default_nettype wire

/* rtl/hnr_front.sv */
// ----------------------------------------------------------------------------
// hnr_front
// Takes items, hashes name bytes, keeps the name buffer, issues commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module hnr_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire hnr_pkg::in_item_t in_item,
  output      logic              q_valid,
  input  wire logic              q_ready,
  output      hnr_pkg::cmd_t     q_cmd,
  input  wire hnr_pkg::nbuf_ctl_t nbuf_ctl,
  output      logic [7:0]        nbuf_data
);
  logic [7:0] nbuf [hnr_pkg::NAME_MAX_LEN];
  logic [31:0] hash;
  logic [31:0] hash_next;
  logic [31:0] mix;
  logic [hnr_pkg::NCNT_W-1:0] cnt;
  logic [hnr_pkg::NCNT_W-1:0] cnt_next;
  logic bad;
  logic bad_next;
  logic pending;
  logic acc;
  logic is_reg;

  assign is_reg    = (in_item.mode == hnr_pkg::MODE_REG);
  assign in_ready  = is_reg ? (!pending && (!in_item.last || q_ready)) : q_ready;
  assign acc       = in_valid && in_ready;
  assign mix       = hash ^ {24'd0, in_item.name_byte};
  assign hash_next = mix * hnr_pkg::FNV_PRIME;
  assign cnt_next  = (cnt <= hnr_pkg::NCNT_W'(hnr_pkg::NAME_MAX_LEN)) ? cnt + 1'b1 : cnt;
  assign bad_next  = bad || (in_item.name_byte == 8'd0);
  assign q_valid   = acc && (!is_reg || in_item.last);

  always_comb begin
    q_cmd.is_lookup = !is_reg;
    q_cmd.bad       = bad_next;
    q_cmd.id        = is_reg ? hash_next : in_item.lookup_id;
    q_cmd.len       = cnt_next;
  end

  always_ff @(posedge clk) begin
    if (acc && is_reg && (cnt < hnr_pkg::NCNT_W'(hnr_pkg::NAME_MAX_LEN))) begin
      nbuf[cnt[hnr_pkg::NAME_W-1:0]] <= in_item.name_byte;
    end
    nbuf_data <= nbuf[nbuf_ctl.addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash    <= hnr_pkg::FNV_BASIS;
      cnt     <= '0;
      bad     <= 1'b0;
      pending <= 1'b0;
    end else begin
      if (nbuf_ctl.done) begin
        pending <= 1'b0;
      end
      if (acc && is_reg) begin
        if (in_item.last) begin
          hash    <= hnr_pkg::FNV_BASIS;
          cnt     <= '0;
          bad     <= 1'b0;
          pending <= 1'b1;
        end else begin
          hash <= hash_next;
          cnt  <= cnt_next;
          bad  <= bad_next;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/hnr_back.sv */
// ----------------------------------------------------------------------------
// hnr_back
// Carries out commands: search, compare, insert, text append, result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module hnr_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire hnr_pkg::cfg_t      cfg,
  input  wire logic               q_valid,
  output      logic               q_pop,
  input  wire hnr_pkg::cmd_t      q_cmd,
  output      hnr_pkg::nbuf_ctl_t nbuf_ctl,
  input  wire logic [7:0]         nbuf_data,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      hnr_pkg::out_item_t out_item
);
  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_SRCH_RD  = 10'b00_0000_0010,
    S_SRCH_CMP = 10'b00_0000_0100,
    S_HIT_CHK  = 10'b00_0000_1000,
    S_TXT_RD   = 10'b00_0001_0000,
    S_TXT_CHK  = 10'b00_0010_0000,
    S_SHF_RD   = 10'b00_0100_0000,
    S_SHF_WR   = 10'b00_1000_0000,
    S_CPY_RD   = 10'b01_0000_0000,
    S_CPY_WR   = 10'b10_0000_0000
  } state_t;

  localparam int CW = hnr_pkg::CNT_W;
  localparam int IW = hnr_pkg::IDX_W;
  localparam int NW = hnr_pkg::NCNT_W;
  localparam int TW = hnr_pkg::TADDR_W;
  localparam int FW = hnr_pkg::TFILL_W;

  hnr_pkg::entry_t entry_mem [hnr_pkg::ENTRIES];
  logic [7:0]      text_mem  [hnr_pkg::TEXT_BYTES];

  state_t state, state_next;
  hnr_pkg::cmd_t cmd, cmd_next, cur;
  logic [CW-1:0] first, first_next, cnt, cnt_next, sidx, sidx_next;
  logic [CW-1:0] total, total_next, mid, half;
  logic [NW-1:0] tidx, tidx_next;
  logic [FW-1:0] fill, fill_next, room, lim_t, pos;
  logic [CW-1:0] lim_e;
  logic [TW-1:0] hit_off, hit_off_next;
  logic oob, oob_next;
  hnr_pkg::entry_t e_rd, e_wdata;
  logic [IW-1:0] e_raddr, e_waddr;
  logic e_we;
  logic [7:0] t_rd, t_wdata;
  logic [TW-1:0] t_raddr, t_waddr;
  logic t_we;
  logic emit, miss, cap_fail;
  hnr_pkg::out_item_t em;
  logic [31:0] fixed_id;

  function automatic logic builtin(input logic [31:0] id, input hnr_pkg::cfg_t c);
    return (id >= c.builtin_first_id) && (id <= c.builtin_last_id);
  endfunction

  assign half  = cnt >> 1;
  assign mid   = first + half;
  assign lim_e = (cfg.entry_limit > CW'(hnr_pkg::ENTRIES)) ? CW'(hnr_pkg::ENTRIES)
                                                           : CW'(cfg.entry_limit);
  assign lim_t = (cfg.text_limit > FW'(hnr_pkg::TEXT_BYTES)) ? FW'(hnr_pkg::TEXT_BYTES)
                                                             : FW'(cfg.text_limit);
  assign room  = (lim_t > fill) ? lim_t - fill : '0;
  assign cap_fail = (total >= lim_e) || ((FW'(cmd.len) + 1'b1) > room);
  assign pos   = FW'(hit_off) + FW'(tidx);
  assign fixed_id = (q_cmd.id == 32'd0) ? 32'd1 : q_cmd.id;

  always_comb begin
    state_next   = state;
    cmd_next     = cmd;
    first_next   = first;
    cnt_next     = cnt;
    sidx_next    = sidx;
    tidx_next    = tidx;
    total_next   = total;
    fill_next    = fill;
    hit_off_next = hit_off;
    oob_next     = oob;
    cur          = (state == S_IDLE) ? q_cmd : cmd;
    q_pop        = 1'b0;
    e_raddr      = first[IW-1:0];
    e_we         = 1'b0;
    e_waddr      = sidx[IW-1:0];
    e_wdata      = e_rd;
    t_raddr      = pos[TW-1:0];
    t_we         = 1'b0;
    t_waddr      = fill[TW-1:0] + TW'(tidx);
    t_wdata      = nbuf_data;
    nbuf_ctl     = '0;
    nbuf_ctl.addr = tidx[hnr_pkg::NAME_W-1:0];
    emit         = 1'b0;
    miss         = 1'b0;
    em           = '0;
    unique case (state)
      S_IDLE: begin
        if (q_valid && (!out_valid || out_ready)) begin
          q_pop      = 1'b1;
          cmd_next   = q_cmd;
          first_next = '0;
          cnt_next   = total;
          if (q_cmd.is_lookup) begin
            if (q_cmd.id == 32'd0) begin
              emit = 1'b1;
              em.status = hnr_pkg::ST_INVALID;
            end else if (!cfg.sealed) begin
              emit = 1'b1;
              em.status = hnr_pkg::ST_SEALED;
            end else if (builtin(q_cmd.id, cfg)) begin
              emit = 1'b1;
              em.status = hnr_pkg::ST_OK;
              em.result_id = q_cmd.id;
              em.is_builtin = 1'b1;
              em.builtin_slot = 8'(q_cmd.id - cfg.builtin_first_id);
            end else begin
              state_next = S_SRCH_RD;
            end
          end else begin
            cmd_next.id = fixed_id;
            if (cfg.sealed) begin
              emit = 1'b1;
              em.status = hnr_pkg::ST_SEALED;
            end else if (q_cmd.bad || (q_cmd.len == '0) ||
                         (q_cmd.len > NW'(hnr_pkg::NAME_MAX_LEN))) begin
              emit = 1'b1;
              em.status = hnr_pkg::ST_INVALID;
            end else if (builtin(fixed_id, cfg)) begin
              emit = 1'b1;
              em.status = hnr_pkg::ST_CONFLICT;
            end else begin
              state_next = S_SRCH_RD;
            end
          end
        end
      end
      S_SRCH_RD: begin
        if (cnt == '0) begin
          if (first < total) begin
            e_raddr    = first[IW-1:0];
            state_next = S_HIT_CHK;
          end else begin
            miss = 1'b1;
          end
        end else begin
          e_raddr    = mid[IW-1:0];
          state_next = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (e_rd.id < cmd.id) begin
          first_next = mid + 1'b1;
          cnt_next   = cnt - half - 1'b1;
        end else begin
          cnt_next = half;
        end
        state_next = S_SRCH_RD;
      end
      S_HIT_CHK: begin
        if (e_rd.id == cmd.id) begin
          if (cmd.is_lookup) begin
            emit = 1'b1;
            em.status = hnr_pkg::ST_OK;
            em.result_id = cmd.id;
            em.text_start = e_rd.off;
            em.text_len = e_rd.len;
          end else if (NW'(e_rd.len) != cmd.len) begin
            emit = 1'b1;
            em.status = hnr_pkg::ST_CONFLICT;
          end else begin
            hit_off_next = e_rd.off;
            tidx_next    = '0;
            state_next   = S_TXT_RD;
          end
        end else begin
          miss = 1'b1;
        end
      end
      S_TXT_RD: begin
        if (tidx == cmd.len) begin
          emit = 1'b1;
          em.status = hnr_pkg::ST_OK;
          em.result_id = cmd.id;
        end else begin
          oob_next   = pos[FW-1];
          state_next = S_TXT_CHK;
        end
      end
      S_TXT_CHK: begin
        if (oob || (t_rd != nbuf_data)) begin
          emit = 1'b1;
          em.status = hnr_pkg::ST_CONFLICT;
        end else begin
          tidx_next  = tidx + 1'b1;
          state_next = S_TXT_RD;
        end
      end
      S_SHF_RD: begin
        if (sidx == first) begin
          e_we       = 1'b1;
          e_waddr    = first[IW-1:0];
          e_wdata.id = cmd.id;
          e_wdata.off = fill[TW-1:0];
          e_wdata.len = cmd.len[7:0];
          tidx_next  = '0;
          state_next = S_CPY_RD;
        end else begin
          e_raddr    = IW'(sidx - 1'b1);
          state_next = S_SHF_WR;
        end
      end
      S_SHF_WR: begin
        e_we       = 1'b1;
        e_waddr    = sidx[IW-1:0];
        sidx_next  = sidx - 1'b1;
        state_next = S_SHF_RD;
      end
      S_CPY_RD: begin
        if (tidx == cmd.len) begin
          t_we       = 1'b1;
          t_wdata    = 8'd0;
          fill_next  = fill + FW'(cmd.len) + 1'b1;
          total_next = total + 1'b1;
          emit = 1'b1;
          em.status = hnr_pkg::ST_OK;
          em.result_id = cmd.id;
        end else begin
          state_next = S_CPY_WR;
        end
      end
      S_CPY_WR: begin
        t_we       = 1'b1;
        tidx_next  = tidx + 1'b1;
        state_next = S_CPY_RD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (miss) begin
      if (cmd.is_lookup) begin
        emit = 1'b1;
        em.status = hnr_pkg::ST_NOTFOUND;
      end else if (cap_fail) begin
        emit = 1'b1;
        em.status = hnr_pkg::ST_CAPACITY;
      end else begin
        sidx_next  = total;
        state_next = S_SHF_RD;
      end
    end
    if (emit) begin
      state_next    = S_IDLE;
      nbuf_ctl.done = !cur.is_lookup;
    end
  end

  always_ff @(posedge clk) begin
    if (e_we) begin
      entry_mem[e_waddr] <= e_wdata;
    end
    e_rd <= entry_mem[e_raddr];
    if (t_we) begin
      text_mem[t_waddr] <= t_wdata;
    end
    t_rd <= text_mem[t_raddr];
  end

  always_ff @(posedge clk) begin
    cmd     <= cmd_next;
    first   <= first_next;
    cnt     <= cnt_next;
    sidx    <= sidx_next;
    tidx    <= tidx_next;
    hit_off <= hit_off_next;
    oob     <= oob_next;
    if (emit) begin
      out_item <= em;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      total     <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      total <= total_next;
      fill  <= fill_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/hashed_name_registry.sv */
// ----------------------------------------------------------------------------
// hashed_name_registry
// FNV-1a keyed registry of user names in a sorted id table.
// ----------------------------------------------------------------------------
// Name bytes: one per cycle while no name is pending and, for a last byte, the
//   queue has room; an item that ends no name gives no result. Last byte or
//   lookup: no search if none is needed, else a binary search, plus a text
//   compare on repeat registration and entry shift and text copy on insert.
// The back handles one command at a time, bound by its single-port table reads.
// Reset (rst, synchronous): counters and control clear, config gets defaults;
//   tables are undefined until written and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module hashed_name_registry (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire hnr_pkg::in_item_t  in_item,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      hnr_pkg::out_item_t out_item,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);
  hnr_pkg::cfg_t      cfg;
  hnr_pkg::cmd_t      f_cmd;
  hnr_pkg::cmd_t      b_cmd;
  hnr_pkg::nbuf_ctl_t nbuf_ctl;
  logic f_valid;
  logic f_ready;
  logic b_valid;
  logic b_pop;
  logic [7:0] nbuf_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.builtin_first_id <= 32'd1;
      cfg.builtin_last_id  <= 32'd8;
      cfg.entry_limit      <= 9'd256;
      cfg.text_limit       <= 13'd4096;
      cfg.sealed           <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hnr_pkg::CFG_FIRST:  cfg.builtin_first_id <= cfg_data;
        hnr_pkg::CFG_LAST:   cfg.builtin_last_id  <= cfg_data;
        hnr_pkg::CFG_ELIMIT: cfg.entry_limit      <= cfg_data[8:0];
        hnr_pkg::CFG_TLIMIT: cfg.text_limit       <= cfg_data[12:0];
        hnr_pkg::CFG_SEALED: cfg.sealed           <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  hnr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .q_valid   (f_valid),
    .q_ready   (f_ready),
    .q_cmd     (f_cmd),
    .nbuf_ctl  (nbuf_ctl),
    .nbuf_data (nbuf_data)
  );

  hnr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_cmd   (f_cmd),
    .rd_valid (b_valid),
    .rd_pop   (b_pop),
    .rd_cmd   (b_cmd)
  );

  hnr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (b_valid),
    .q_pop     (b_pop),
    .q_cmd     (b_cmd),
    .nbuf_ctl  (nbuf_ctl),
    .nbuf_data (nbuf_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );
endmodule
`default_nettype wire

/* rtl/hnr_checker.sv */
// ----------------------------------------------------------------------------
// hnr_checker
// Port-level checks of the registry results, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "hashed_name_registry_macros.svh"
module hnr_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire hnr_pkg::out_item_t out_item
);
  `HNR_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_item), "item dropped")
  `HNR_ASSERT(a_status_range, out_valid |-> out_item.status <= hnr_pkg::ST_NOTFOUND, "bad status")
  `HNR_ASSERT(a_err_zero, out_valid && out_item.status != hnr_pkg::ST_OK |-> out_item.result_id == 32'd0 && !out_item.is_builtin, "error carries id")
  `HNR_ASSERT(a_builtin_no_text, out_valid && out_item.is_builtin |-> out_item.text_start == 12'd0 && out_item.text_len == 8'd0, "builtin with text")
endmodule

bind hashed_name_registry hnr_checker u_hnr_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
`default_nettype wire

/* tb/sv/hashed_name_registry_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_name_registry_checker
// Watches the item, result and register ports of the name registry, keeps
// its own copy of the sorted id table and text store, predicts each result
// and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module hashed_name_registry_checker
  import hnr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_item,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fails,
  output int          pending,
  output int          results
);

  logic [31:0] first_id, last_id;
  logic [8:0]  entry_lim;
  logic [12:0] text_lim;
  logic        is_sealed;

  logic [31:0] id_tab  [ENTRIES];
  logic [11:0] off_tab [ENTRIES];
  logic [7:0]  len_tab [ENTRIES];
  logic [7:0]  text_mem[TEXT_BYTES];
  logic [7:0]  name_mem[NAME_MAX_LEN];
  int          entry_cnt, fill_bytes, name_cnt;
  logic [31:0] hash_q;
  bit          name_bad;

  out_item_t   result_q[$];
  out_item_t   want;
  int          fail_n, result_n;

  function automatic bit builtin_hit(logic [31:0] id);
    return id >= first_id && id <= last_id;
  endfunction

  function automatic int find_slot(logic [31:0] id);
    int lo, cnt, half;
    lo = 0;
    cnt = entry_cnt;
    while (cnt != 0) begin
      half = cnt / 2;
      if (id_tab[lo + half] < id) begin
        lo = lo + half + 1;
        cnt = cnt - half - 1;
      end else begin
        cnt = half;
      end
    end
    return lo;
  endfunction

  task automatic close_name(output logic [2:0] st, output logic [31:0] rid);
    logic [31:0] id;
    int idx, le, lt, room;
    rid = '0;
    if (is_sealed) begin
      st = ST_SEALED;
      return;
    end
    if (name_bad || name_cnt == 0 || name_cnt > NAME_MAX_LEN) begin
      st = ST_INVALID;
      return;
    end
    id = (hash_q == 0) ? 32'd1 : hash_q;
    if (builtin_hit(id)) begin
      st = ST_CONFLICT;
      return;
    end
    idx = find_slot(id);
    if (idx < entry_cnt && id_tab[idx] == id) begin
      st = ST_OK;
      if (len_tab[idx] != name_cnt) st = ST_CONFLICT;
      for (int i = 0; i < name_cnt && st == ST_OK; i++)
        if (text_mem[off_tab[idx] + i] != name_mem[i]) st = ST_CONFLICT;
      if (st == ST_OK) rid = id;
      return;
    end
    le = (entry_lim < ENTRIES) ? entry_lim : ENTRIES;
    lt = (text_lim < TEXT_BYTES) ? text_lim : TEXT_BYTES;
    room = (lt > fill_bytes) ? lt - fill_bytes : 0;
    if (entry_cnt >= le || name_cnt + 1 > room) begin
      st = ST_CAPACITY;
      return;
    end
    for (int i = entry_cnt; i > idx; i--) begin
      id_tab[i]  = id_tab[i-1];
      off_tab[i] = off_tab[i-1];
      len_tab[i] = len_tab[i-1];
    end
    for (int i = 0; i < name_cnt; i++) text_mem[fill_bytes + i] = name_mem[i];
    text_mem[fill_bytes + name_cnt] = 8'd0;
    id_tab[idx]  = id;
    off_tab[idx] = fill_bytes[11:0];
    len_tab[idx] = name_cnt[7:0];
    fill_bytes += name_cnt + 1;
    entry_cnt++;
    st = ST_OK;
    rid = id;
  endtask

  task automatic take_item(in_item_t it);
    out_item_t r;
    int idx;
    r = '0;
    if (it.mode == MODE_REG) begin
      if (it.name_byte == 8'd0) name_bad = 1;
      if (name_cnt < NAME_MAX_LEN) name_mem[name_cnt] = it.name_byte;
      if (name_cnt <= NAME_MAX_LEN) name_cnt++;
      hash_q = (hash_q ^ {24'd0, it.name_byte}) * FNV_PRIME;
      if (!it.last) return;
      close_name(r.status, r.result_id);
      hash_q = FNV_BASIS;
      name_cnt = 0;
      name_bad = 0;
    end else if (it.lookup_id == 32'd0) begin
      r.status = ST_INVALID;
    end else if (!is_sealed) begin
      r.status = ST_SEALED;
    end else if (builtin_hit(it.lookup_id)) begin
      r.status = ST_OK;
      r.result_id = it.lookup_id;
      r.is_builtin = 1'b1;
      r.builtin_slot = 8'(it.lookup_id - first_id);
    end else begin
      idx = find_slot(it.lookup_id);
      if (idx >= entry_cnt || id_tab[idx] != it.lookup_id) begin
        r.status = ST_NOTFOUND;
      end else begin
        r.status = ST_OK;
        r.result_id = it.lookup_id;
        r.text_start = off_tab[idx];
        r.text_len = len_tab[idx];
      end
    end
    result_q.push_back(r);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      first_id = 32'd1;
      last_id = 32'd8;
      entry_lim = 9'd256;
      text_lim = 13'd4096;
      is_sealed = 0;
      entry_cnt = 0;
      fill_bytes = 0;
      name_cnt = 0;
      name_bad = 0;
      hash_q = FNV_BASIS;
      result_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FIRST:  first_id = cfg_data;
          CFG_LAST:   last_id = cfg_data;
          CFG_ELIMIT: entry_lim = cfg_data[8:0];
          CFG_TLIMIT: text_lim = cfg_data[12:0];
          CFG_SEALED: is_sealed = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) take_item(in_item);
      if (out_valid && out_ready) begin
        result_n++;
        if (result_q.size() == 0) begin
          $error("result with none pending: status %0d id %h", out_item.status,
                 out_item.result_id);
          fail_n++;
        end else begin
          want = result_q.pop_front();
          if (out_item.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, out_item.status);
            fail_n++;
          end
          if (out_item.result_id !== want.result_id) begin
            $error("result_id expected %h got %h", want.result_id, out_item.result_id);
            fail_n++;
          end
          if (out_item.is_builtin !== want.is_builtin) begin
            $error("is_builtin expected %0d got %0d", want.is_builtin, out_item.is_builtin);
            fail_n++;
          end
          if (out_item.builtin_slot !== want.builtin_slot) begin
            $error("builtin_slot expected %0d got %0d", want.builtin_slot,
                   out_item.builtin_slot);
            fail_n++;
          end
          if (out_item.text_start !== want.text_start) begin
            $error("text_start expected %0d got %0d", want.text_start, out_item.text_start);
            fail_n++;
          end
          if (out_item.text_len !== want.text_len) begin
            $error("text_len expected %0d got %0d", want.text_len, out_item.text_len);
            fail_n++;
          end
        end
      end
    end
    fails <= fail_n + result_q.size() * 0;
    pending <= result_q.size();
    results <= result_n;
  end

  initial begin
    fail_n = 0;
    result_n = 0;
    fails = 0;
    pending = 0;
    results = 0;
  end

endmodule

/* tb/sv/hashed_name_registry_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_name_registry_tb
// Drives name bytes and id lookups into the registry through several register
// settings (builtin ranges, entry and text limits, sealed and unsealed), with
// random gaps on both channels; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module hashed_name_registry_tb;
  import hnr_pkg::*;

  localparam int IDLE_LIMIT = 50000;
  localparam int SETTLE     = 1200;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 0;
  out_item_t   out_item;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int          fails, pending, results;
  int          n_items, n_cfg, idle_cnt, hold;
  bit          calm;
  logic [7:0]  nm[$];
  logic [31:0] known_ids[$];
  logic [31:0] cur_first = 32'd1, cur_last = 32'd8;

  hashed_name_registry dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  hashed_name_registry_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fails(fails), .pending(pending), .results(results)
  );

  always #5 clk = ~clk;

  // receiver stalls: mostly short, a few long, none while calm
  always @(posedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
      hold <= 0;
    end else if (hold == 0) begin
      if ($urandom % 4 != 0) begin
        out_ready <= 1'b1;
        hold <= $urandom_range(1, 30);
      end else begin
        out_ready <= 1'b0;
        hold <= ($urandom % 10 == 0) ? $urandom_range(20, 200) : $urandom_range(1, 3);
      end
    end else begin
      hold <= hold - 1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("hashed_name_registry_tb failed");
      $finish;
    end
  end

  function automatic logic [31:0] name_hash();
    logic [31:0] h;
    h = FNV_BASIS;
    foreach (nm[i]) h = (h ^ {24'd0, nm[i]}) * FNV_PRIME;
    return (h == 0) ? 32'd1 : h;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom % 100;
    if (calm || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 100);
  endfunction

  task automatic send(logic mode, logic [7:0] b, logic fin, logic [31:0] id);
    int g;
    in_item_t it;
    it.mode = mode;
    it.name_byte = b;
    it.last = fin;
    it.lookup_id = id;
    in_item <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    n_items++;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic hold_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic lookup(logic [31:0] id);
    send(MODE_LOOKUP, 8'($urandom), 1'($urandom), id);
  endtask

  task automatic send_name(bit mid_lookups);
    foreach (nm[i]) begin
      send(MODE_REG, nm[i], i == nm.size() - 1, $urandom);
      if (mid_lookups && i != nm.size() - 1 && $urandom % 30 == 0) lookup($urandom);
    end
    known_ids.push_back(name_hash());
  endtask

  task automatic pool_name(int k);
    nm.delete();
    for (int i = 0; i <= k % 7; i++) nm.push_back(8'(1 + (k * 37 + i * 101) % 255));
  endtask

  task automatic rand_name(int len, bit zeros);
    nm.delete();
    repeat (len) nm.push_back((zeros && $urandom % 8 == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    n_cfg++;
    if (idx == CFG_FIRST) cur_first = v;
    if (idx == CFG_LAST) cur_last = v;
  endtask

  task automatic settle();
    hold_input();
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic rand_lookup();
    int r;
    logic [31:0] span;
    r = $urandom % 10;
    span = (cur_last - cur_first > 255) ? 255 : cur_last - cur_first;
    if (r < 5 && known_ids.size() > 0) lookup(known_ids[$urandom % known_ids.size()]);
    else if (r < 7 && cur_first <= cur_last) lookup(cur_first + $urandom_range(0, span));
    else if (r == 7) lookup(32'd0);
    else lookup($urandom);
  endtask

  task automatic reg_burst(int count, int pool);
    int stop, r;
    stop = n_items + count;
    while (n_items < stop) begin
      calm = (n_items % 400) < 60;
      r = $urandom % 100;
      if (r < 60) pool_name($urandom % pool);
      else if (r < 85) rand_name(($urandom % 10 == 0) ? $urandom_range(8, 40)
                                 : $urandom_range(1, 6), 0);
      else if (r < 92) rand_name($urandom_range(1, 6), 1);
      else if (r == 92) rand_name($urandom_range(255, 256), 0);
      else begin
        rand_lookup();
        continue;
      end
      send_name(1);
    end
    calm = 0;
  endtask

  task automatic lookup_burst(int count);
    int stop;
    stop = n_items + count;
    while (n_items < stop) begin
      if ($urandom % 12 == 0) begin
        pool_name($urandom % 400);
        send_name(0);
      end else begin
        rand_lookup();
      end
    end
  endtask

  initial begin
    n_items = 0;
    n_cfg = 0;
    idle_cnt = 0;
    hold = 0;
    calm = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: repeat name, zero byte, overlong, unsealed lookups, mid-name lookup
    nm = '{8'h61};
    send_name(0);
    send_name(0);
    nm = '{8'h62, 8'h00, 8'h63};
    send_name(0);
    rand_name(256, 0);
    send_name(0);
    lookup(32'd0);
    lookup(32'hFFFFFFFF);
    send(MODE_REG, 8'hFF, 1'b0, 32'hFFFFFFFF);
    lookup(32'h12345678);
    send(MODE_REG, 8'h80, 1'b1, 32'd0);
    nm = '{8'hFF, 8'h80};
    known_ids.push_back(name_hash());
    settle();

    // name hashed into the builtin range, then full and empty ranges
    nm = '{8'h78, 8'h79};
    cfg_write(CFG_FIRST, name_hash() - 2);
    cfg_write(CFG_LAST, name_hash() + 2);
    send_name(0);
    settle();
    cfg_write(CFG_FIRST, 32'd0);
    cfg_write(CFG_LAST, 32'hFFFFFFFF);
    pool_name(3);
    send_name(0);
    settle();
    cfg_write(CFG_FIRST, 32'd100);
    cfg_write(CFG_LAST, 32'd50);
    cfg_write(CFG_ELIMIT, 9'd0);
    pool_name(5);
    send_name(0);
    settle();

    cfg_write(CFG_FIRST, 32'hFFFFFF00);
    cfg_write(CFG_LAST, 32'hFFFFFFFF);
    cfg_write(CFG_ELIMIT, 9'd40);
    cfg_write(CFG_TLIMIT, 13'd300);
    reg_burst(450, 600);
    settle();

    cfg_write(CFG_ELIMIT, 9'd511);
    cfg_write(CFG_TLIMIT, 13'd8191);
    reg_burst(550, 600);
    settle();

    cfg_write(CFG_SEALED, 1'b1);
    lookup(cur_first);
    lookup(cur_last);
    lookup(32'd0);
    reg_burst(0, 1);
    lookup_burst(400);
    settle();

    cfg_write(CFG_SEALED, 1'b0);
    cfg_write(CFG_ELIMIT, 9'd256);
    cfg_write(CFG_TLIMIT, 13'd4096);
    cfg_write(CFG_FIRST, 32'd1);
    cfg_write(CFG_LAST, 32'd8);
    reg_burst(350, 900);
    settle();
    cfg_write(CFG_TLIMIT, 13'd0);
    reg_burst(40, 900);
    settle();
    cfg_write(CFG_SEALED, 1'b1);
    lookup_burst(250);
    settle();

    $display("ran %0d items and %0d register writes, %0d results checked",
             n_items, n_cfg, results);
    if (fails == 0 && pending == 0) begin
      $display("hashed_name_registry_tb passed");
    end else begin
      $display("hashed_name_registry_tb failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/hnr_pkg.sv
rtl/hnr_queue.sv
rtl/hnr_front.sv
rtl/hnr_back.sv
rtl/hashed_name_registry.sv
rtl/hnr_checker.sv
tb/sv/hashed_name_registry_checker.sv
tb/sv/hashed_name_registry_tb.sv
